// ===== hdl/bf5_pkg.sv =====
// ----------------------------------------------------------------------------
// bf5_pkg: shared types and constants of the 5x5 bilateral filter
// Field widths, item action codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bf5_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned WGT_W     = 16;

  // Row counter width and its saturation value.
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned ROW_LIMIT = 4095;

  // Range weight table is addressed by an 8-bit intensity difference.
  localparam int unsigned RANGE_DEPTH = 256;

  // Window coordinates fit three bits for a radius of at most 3.
  localparam int unsigned WIN_IDX_W = 3;

  // Cycles between the last multiply issue and a settled accumulator.
  localparam int unsigned DRAIN_CYCLES = 3;

  // One quotient bit per divider step; the quotient is a pixel.
  localparam int unsigned DIV_STEPS = PIX_W;

  // Defaults for the top-level parameters and the length register.
  localparam int unsigned DEF_RADIUS         = 2;
  localparam int unsigned DEF_MAX_ROW_LENGTH = 1024;
  localparam int unsigned RESET_ROW_LENGTH   = 1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_RANGE   = 2'd1,
    ACT_SPATIAL = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 range_we;
    logic                 spat_we;
    logic                 pix_capture;
    logic                 line_shift;
    logic                 acc_clear;
    logic                 mac_issue;
    logic [WIN_IDX_W-1:0] win_row;
    logic [WIN_IDX_W-1:0] win_col;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
    logic                 out_first;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== hdl/bf5_ram.sv =====
// ----------------------------------------------------------------------------
// bf5_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bf5_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bf5_ctrl.sv =====
// ----------------------------------------------------------------------------
// bf5_ctrl: controller of the bilateral filter
// Takes items, tracks the raster position, and sequences line update,
// weighted accumulation, division and result hand-off.
// ----------------------------------------------------------------------------
module bf5_ctrl #(
  parameter int unsigned WINDOW_RADIUS  = bf5_pkg::DEF_RADIUS,
  parameter int unsigned MAX_ROW_LENGTH = bf5_pkg::DEF_MAX_ROW_LENGTH,
  localparam int unsigned CW            = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bf5_pkg::ACT_W-1:0]   action_i,
  input  logic                        frame_start_i,
  input  logic [bf5_pkg::IDX_W-1:0]   table_index_i,
  input  logic                        len_we_i,
  input  logic [bf5_pkg::CFG_W-1:0]   len_i,
  input  bf5_pkg::status_t            status_i,
  output bf5_pkg::cmd_t               cmd_o,
  output logic [CW-1:0]               line_raddr_o,
  output logic [CW-1:0]               line_waddr_o
);

  localparam int unsigned SPAN      = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned LINES     = 2 * WINDOW_RADIUS;
  localparam int unsigned SP_DEPTH  = 2 * WINDOW_RADIUS * WINDOW_RADIUS + 1;
  localparam int unsigned LW_MAX    = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned LW        = (LW_MAX > bf5_pkg::CFG_W) ? LW_MAX : bf5_pkg::CFG_W;
  localparam int unsigned DRW       = $clog2(bf5_pkg::DRAIN_CYCLES);
  localparam int unsigned DVW       = $clog2(bf5_pkg::DIV_STEPS);

  bf5_pkg::state_e state_q, state_d;

  logic [bf5_pkg::CFG_W-1:0]     len_q;
  logic [CW-1:0]                 col_q, col_d;
  logic [bf5_pkg::ROW_W-1:0]     row_q, row_d;
  logic [CW-1:0]                 cur_col_q, cur_col_d;
  logic                          produce_q, produce_d;
  logic                          first_q, first_d;
  logic [bf5_pkg::WIN_IDX_W-1:0] win_row_q, win_col_q;
  logic [DRW-1:0]                drain_q;
  logic [DVW-1:0]                div_q;

  logic                          accept;
  logic                          is_pixel;
  logic [LW-1:0]                 len_eff;
  logic [LW-1:0]                 col_start;
  logic [bf5_pkg::ROW_W-1:0]     row_start;
  logic [LW-1:0]                 col_inc;
  logic                          mac_last;

  function automatic logic [bf5_pkg::ROW_W-1:0] row_step(
    input logic [bf5_pkg::ROW_W-1:0] row
  );
    if (row == bf5_pkg::ROW_W'(bf5_pkg::ROW_LIMIT)) begin
      return row;
    end
    return row + bf5_pkg::ROW_W'(1);
  endfunction

  assign in_ready_o = (state_q == bf5_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (action_i == bf5_pkg::ACT_PIXEL);

  // Raster position of an arriving pixel, with length clamping.
  always_comb begin
    len_eff = LW'(len_q);
    if (len_eff < LW'(SPAN)) begin
      len_eff = LW'(SPAN);
    end
    if (len_eff > LW'(MAX_ROW_LENGTH)) begin
      len_eff = LW'(MAX_ROW_LENGTH);
    end
    col_start = frame_start_i ? '0 : LW'(col_q);
    row_start = frame_start_i ? '0 : row_q;
    if (col_start >= len_eff) begin
      col_start = '0;
      row_start = row_step(row_start);
    end
    cur_col_d = col_start[CW-1:0];
    produce_d = (row_start >= bf5_pkg::ROW_W'(LINES)) && (col_start >= LW'(LINES));
    first_d   = (row_start == bf5_pkg::ROW_W'(LINES)) && (col_start == LW'(LINES));
    col_inc   = col_start + LW'(1);
    if (col_inc >= len_eff) begin
      col_d = '0;
      row_d = row_step(row_start);
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_start;
    end
  end

  assign mac_last = (win_row_q == bf5_pkg::WIN_IDX_W'(SPAN - 1)) &&
                    (win_col_q == bf5_pkg::WIN_IDX_W'(SPAN - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bf5_pkg::ST_IDLE: begin
        if (accept && is_pixel) begin
          state_d = bf5_pkg::ST_LINE;
        end
      end
      bf5_pkg::ST_LINE: begin
        state_d = produce_q ? bf5_pkg::ST_MAC : bf5_pkg::ST_IDLE;
      end
      bf5_pkg::ST_MAC: begin
        if (mac_last) begin
          state_d = bf5_pkg::ST_DRAIN;
        end
      end
      bf5_pkg::ST_DRAIN: begin
        if (drain_q == DRW'(bf5_pkg::DRAIN_CYCLES - 1)) begin
          state_d = bf5_pkg::ST_DIV_INIT;
        end
      end
      bf5_pkg::ST_DIV_INIT: begin
        state_d = bf5_pkg::ST_DIV;
      end
      bf5_pkg::ST_DIV: begin
        if (div_q == DVW'(bf5_pkg::DIV_STEPS - 1)) begin
          state_d = bf5_pkg::ST_OUT;
        end
      end
      bf5_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          state_d = bf5_pkg::ST_IDLE;
        end
      end
      default: state_d = bf5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.range_we    = accept && (action_i == bf5_pkg::ACT_RANGE);
    cmd_o.spat_we     = accept && (action_i == bf5_pkg::ACT_SPATIAL) &&
                        (table_index_i < bf5_pkg::IDX_W'(SP_DEPTH));
    cmd_o.pix_capture = accept && is_pixel;
    cmd_o.win_row     = win_row_q;
    cmd_o.win_col     = win_col_q;
    cmd_o.out_first   = first_q;
    unique case (state_q)
      bf5_pkg::ST_LINE: begin
        cmd_o.line_shift = 1'b1;
        cmd_o.acc_clear  = 1'b1;
      end
      bf5_pkg::ST_MAC:      cmd_o.mac_issue = 1'b1;
      bf5_pkg::ST_DIV_INIT: cmd_o.div_init  = 1'b1;
      bf5_pkg::ST_DIV:      cmd_o.div_step  = 1'b1;
      bf5_pkg::ST_OUT:      cmd_o.out_load  = status_i.out_free;
      default: ;
    endcase
  end

  assign line_raddr_o = cur_col_d;
  assign line_waddr_o = cur_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bf5_pkg::ST_IDLE;
      len_q     <= bf5_pkg::CFG_W'(bf5_pkg::RESET_ROW_LENGTH);
      col_q     <= '0;
      row_q     <= '0;
      cur_col_q <= '0;
      produce_q <= 1'b0;
      first_q   <= 1'b0;
      win_row_q <= '0;
      win_col_q <= '0;
      drain_q   <= '0;
      div_q     <= '0;
    end else begin
      state_q <= state_d;
      if (len_we_i) begin
        len_q <= len_i;
      end
      if (accept && is_pixel) begin
        col_q     <= col_d;
        row_q     <= row_d;
        cur_col_q <= cur_col_d;
        produce_q <= produce_d;
        first_q   <= first_d;
      end
      if (state_q == bf5_pkg::ST_LINE) begin
        win_row_q <= '0;
        win_col_q <= '0;
      end else if (state_q == bf5_pkg::ST_MAC) begin
        if (win_col_q == bf5_pkg::WIN_IDX_W'(SPAN - 1)) begin
          win_col_q <= '0;
          win_row_q <= win_row_q + bf5_pkg::WIN_IDX_W'(1);
        end else begin
          win_col_q <= win_col_q + bf5_pkg::WIN_IDX_W'(1);
        end
      end
      drain_q <= (state_q == bf5_pkg::ST_DRAIN) ? drain_q + DRW'(1) : '0;
      div_q   <= (state_q == bf5_pkg::ST_DIV) ? div_q + DVW'(1) : '0;
    end
  end

endmodule

// ===== hdl/bf5_datapath.sv =====
// ----------------------------------------------------------------------------
// bf5_datapath: window, weight tables, accumulator and divider
// Holds the line stores and window, forms one weighted term per cycle
// through a three-stage multiply pipeline, and divides bit by bit.
// ----------------------------------------------------------------------------
module bf5_datapath #(
  parameter int unsigned WINDOW_RADIUS  = bf5_pkg::DEF_RADIUS,
  parameter int unsigned MAX_ROW_LENGTH = bf5_pkg::DEF_MAX_ROW_LENGTH,
  localparam int unsigned CW            = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bf5_pkg::cmd_t               cmd_i,
  output bf5_pkg::status_t            status_o,
  input  logic [CW-1:0]               line_raddr_i,
  input  logic [CW-1:0]               line_waddr_i,
  input  logic [bf5_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic [bf5_pkg::IDX_W-1:0]   table_index_i,
  input  logic [bf5_pkg::WGT_W-1:0]   weight_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bf5_pkg::PIX_W-1:0]   filtered_pixel_o,
  output logic                        first_of_frame_o
);

  localparam int unsigned PW       = bf5_pkg::PIX_W;
  localparam int unsigned SPAN     = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned LINES    = 2 * WINDOW_RADIUS;
  localparam int unsigned SW       = $clog2(SPAN);
  localparam int unsigned SP_DEPTH = 2 * WINDOW_RADIUS * WINDOW_RADIUS + 1;
  localparam int unsigned SPW      = $clog2(SP_DEPTH);
  localparam int unsigned RW       = $clog2(bf5_pkg::RANGE_DEPTH);
  localparam int unsigned W_W      = 2 * bf5_pkg::WGT_W;
  localparam int unsigned PR_W     = W_W + PW;
  localparam int unsigned AW       = $clog2(SPAN * SPAN);
  localparam int unsigned NUM_W    = PR_W + AW;
  localparam int unsigned DEN_W    = W_W + AW;
  localparam int unsigned REM_W    = NUM_W + 1;

  logic [PW-1:0]            win_q [SPAN][SPAN];
  logic [PW-1:0]            pix_q;
  logic [PW*LINES-1:0]      line_rdata;
  logic [PW*LINES-1:0]      line_wdata;
  logic [bf5_pkg::WGT_W-1:0] spat_q [SP_DEPTH];
  logic [bf5_pkg::WGT_W-1:0] range_rdata;

  logic [PW-1:0]            centre;
  logic [PW-1:0]            p0;
  logic [PW-1:0]            diff0;
  logic [SW-1:0]            row0, col0;
  logic [SW-1:0]            dy0, dx0;
  logic [SPW-1:0]           dist0;

  logic                     v1_q, v2_q, v3_q;
  logic [PW-1:0]            p1_q, p2_q;
  logic [SPW-1:0]           dist1_q;
  logic [W_W-1:0]           w2_q, w3_q;
  logic [PR_W-1:0]          prod3_q;
  logic [NUM_W-1:0]         num_q;
  logic [DEN_W-1:0]         den_q;
  logic [REM_W-1:0]         rem_q, dsh_q;
  logic [PW-1:0]            quo_q;

  logic                     out_valid_q;
  logic [PW-1:0]            out_pix_q;
  logic                     out_first_q;

  // Line stores: lane r of the word is line r, the oldest line in lane 0.
  bf5_ram #(
    .WIDTH (PW * LINES),
    .DEPTH (MAX_ROW_LENGTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_shift),
    .waddr_i (line_waddr_i),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr_i),
    .rdata_o (line_rdata)
  );

  bf5_ram #(
    .WIDTH (bf5_pkg::WGT_W),
    .DEPTH (bf5_pkg::RANGE_DEPTH)
  ) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.range_we),
    .waddr_i (table_index_i[RW-1:0]),
    .wdata_i (weight_value_i),
    .raddr_i (diff0[RW-1:0]),
    .rdata_o (range_rdata)
  );

  always_comb begin
    for (int r = 0; r < LINES - 1; r++) begin
      line_wdata[r*PW +: PW] = line_rdata[(r+1)*PW +: PW];
    end
    line_wdata[(LINES-1)*PW +: PW] = pix_q;
  end

  assign centre = win_q[WINDOW_RADIUS][WINDOW_RADIUS];
  assign row0   = cmd_i.win_row[SW-1:0];
  assign col0   = cmd_i.win_col[SW-1:0];
  assign p0     = win_q[row0][col0];
  assign diff0  = (centre > p0) ? centre - p0 : p0 - centre;
  assign dy0    = (row0 >= SW'(WINDOW_RADIUS)) ? row0 - SW'(WINDOW_RADIUS)
                                               : SW'(WINDOW_RADIUS) - row0;
  assign dx0    = (col0 >= SW'(WINDOW_RADIUS)) ? col0 - SW'(WINDOW_RADIUS)
                                               : SW'(WINDOW_RADIUS) - col0;
  assign dist0  = SPW'(dy0 * dy0) + SPW'(dx0 * dx0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SPAN; r++) begin
        for (int k = 0; k < SPAN; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else if (cmd_i.line_shift) begin
      for (int r = 0; r < SPAN; r++) begin
        for (int k = 0; k < SPAN - 1; k++) begin
          win_q[r][k] <= win_q[r][k+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win_q[r][SPAN-1] <= line_rdata[r*PW +: PW];
      end
      win_q[SPAN-1][SPAN-1] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_capture) begin
      pix_q <= pixel_value_i;
    end
    if (cmd_i.spat_we) begin
      spat_q[table_index_i[SPW-1:0]] <= weight_value_i;
    end
  end

  // Multiply pipeline: range read, weight product, weighted pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p0;
    dist1_q <= dist0;
    p2_q    <= p1_q;
    w2_q    <= W_W'(range_rdata) * W_W'(spat_q[dist1_q]);
    w3_q    <= w2_q;
    prod3_q <= PR_W'(w2_q) * PR_W'(p2_q);
    if (cmd_i.acc_clear) begin
      num_q <= '0;
      den_q <= '0;
    end else if (v3_q) begin
      num_q <= num_q + NUM_W'(prod3_q);
      den_q <= den_q + DEN_W'(w3_q);
    end
    // Restoring division; the rounded quotient never exceeds a pixel.
    if (cmd_i.div_init) begin
      rem_q <= REM_W'(num_q) + REM_W'(den_q >> 1);
      dsh_q <= REM_W'(den_q) << (bf5_pkg::DIV_STEPS - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[PW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[PW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_pix_q   <= (den_q == '0) ? centre : quo_q;
      out_first_q <= cmd_i.out_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign filtered_pixel_o  = out_pix_q;
  assign first_of_frame_o  = out_first_q;

endmodule

// ===== hdl/bilateral_filter_5x5.sv =====
// ----------------------------------------------------------------------------
// bilateral_filter_5x5: edge-preserving smoothing of a raster pixel stream
// Top level: controller plus datapath with line stores and weight tables.
// ----------------------------------------------------------------------------
// Feed edge-padded frames in raster order with action set to pixel, and load
// the range table (256 entries, by absolute intensity difference) and the
// spatial table (by squared distance from the centre) beforehand with the
// two load actions. A table load or a transfer with the reserved action leaves
// the block idle, and a pixel outside the valid window region reads the line
// stores and then shifts the window. A pixel that completes a full window
// goes through the line read and the window shift, one multiply issue per
// window position, a drain of the multiply pipeline to settle the
// accumulator, a set-up step and a one-bit-per-cycle restoring divider for
// the rounded quotient, and the hand-off of the result to the output
// register. The output register lets a new transfer start while a result
// still waits; the next result then holds the block until the previous one
// is taken. The row length register may be written only while the block is
// idle; there is no clearing pass after reset, and the tables must be loaded
// before pixels that read them.
module bilateral_filter_5x5 #(
  parameter int unsigned WINDOW_RADIUS  = bf5_pkg::DEF_RADIUS,
  parameter int unsigned MAX_ROW_LENGTH = bf5_pkg::DEF_MAX_ROW_LENGTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        padded_row_length_we_i,
  input  logic [bf5_pkg::CFG_W-1:0]   padded_row_length_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bf5_pkg::ACT_W-1:0]   action_i,
  input  logic [bf5_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic                        frame_start_i,
  input  logic [bf5_pkg::IDX_W-1:0]   table_index_i,
  input  logic [bf5_pkg::WGT_W-1:0]   weight_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bf5_pkg::PIX_W-1:0]   filtered_pixel_o,
  output logic                        first_of_frame_o
);

  localparam int unsigned CW = $clog2(MAX_ROW_LENGTH);

  bf5_pkg::cmd_t    cmd;
  bf5_pkg::status_t status;
  logic [CW-1:0]    line_raddr;
  logic [CW-1:0]    line_waddr;

  // The controller owns the raster position and the sequencing.
  bf5_ctrl #(
    .WINDOW_RADIUS  (WINDOW_RADIUS),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .frame_start_i (frame_start_i),
    .table_index_i (table_index_i),
    .len_we_i      (padded_row_length_we_i),
    .len_i         (padded_row_length_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .line_raddr_o  (line_raddr),
    .line_waddr_o  (line_waddr)
  );

  // The datapath holds all pixel and weight storage and the arithmetic.
  bf5_datapath #(
    .WINDOW_RADIUS  (WINDOW_RADIUS),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .line_raddr_i     (line_raddr),
    .line_waddr_i     (line_waddr),
    .pixel_value_i    (pixel_value_i),
    .table_index_i    (table_index_i),
    .weight_value_i   (weight_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_pixel_o (filtered_pixel_o),
    .first_of_frame_o (first_of_frame_o)
  );

endmodule

// ===== hdl/bf5_checker.sv =====
// ----------------------------------------------------------------------------
// bf5_checker: port-level checks of the bilateral filter
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module bf5_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [bf5_pkg::ACT_W-1:0] action_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [bf5_pkg::PIX_W-1:0] filtered_pixel_o,
  input logic                      first_of_frame_o
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_pixel_o) &&
                                    $stable(first_of_frame_o))
    else $error("stalled result changed");

  // A table load never brings a result out on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i != bf5_pkg::ACT_PIXEL) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after a table load");

  // No result appears straight after a pixel transfer while none is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == bf5_pkg::ACT_PIXEL) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared one cycle after a pixel");

endmodule

bind bilateral_filter_5x5 bf5_checker u_bf5_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .action_i         (action_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .filtered_pixel_o (filtered_pixel_o),
  .first_of_frame_o (first_of_frame_o)
);
